FILE: hw/rtl/shifting_array_store_defines.svh
`ifndef SHIFTING_ARRAY_STORE_DEFINES_SVH
`define SHIFTING_ARRAY_STORE_DEFINES_SVH

// Assertion helpers. Synthesis builds define SYNTH and get empty bodies.
`ifndef SYNTH
`define SAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shifting_array_store: same-cycle check failed");
`else
`define SAS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`endif

`ifndef SYNTH
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shifting_array_store: next-cycle check failed");
`else
`define SAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/sas_pkg.sv
`default_nettype none

package sas_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int IDX_W  = 6;
  localparam int POS_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_SET    = 3'd3,
    KIND_COUNT  = 3'd4,
    KIND_DUMP   = 3'd5
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [IDX_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    logic                     op_error;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic              upd;
    logic              rot;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sas_cell.sv
`default_nettype none

module sas_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sas_pkg::cell_cmd_t          cmd,
  input  logic [sas_pkg::POS_W-1:0]   pos,
  input  logic [sas_pkg::WORD_W-1:0]  low_word,
  input  logic [sas_pkg::WORD_W-1:0]  high_word,
  output logic [sas_pkg::WORD_W-1:0]  word
);
  import sas_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic [IDX_W-1:0]  pos_ext;
  logic              at_idx;
  logic              above_idx;

  always_comb begin
    pos_ext   = IDX_W'(pos);
    at_idx    = (pos_ext == cmd.index);
    above_idx = (pos_ext > cmd.index);
    word_nxt  = word_r;
    if (cmd.rot) begin
      word_nxt = high_word;
    end else if (cmd.upd) begin
      case (kind_e'(cmd.kind))
        KIND_INSERT: begin
          if (above_idx) begin
            word_nxt = low_word;
          end else if (at_idx) begin
            word_nxt = cmd.value;
          end
        end
        KIND_REMOVE: begin
          if (at_idx || above_idx) begin
            word_nxt = high_word;
          end
        end
        KIND_SET: begin
          if (at_idx) begin
            word_nxt = cmd.value;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r <= '0;
    end else begin
      word_r <= word_nxt;
    end
  end

  assign word = word_r;

endmodule

`default_nettype wire

FILE: hw/rtl/shifting_array_store.sv
// Channel  Direction  Payload     Transfer when
// in_      input      in_item_t   in_valid && !in_stall
// out_     output     out_item_t  out_valid && !out_stall
//
// Insert, remove and set take one cycle; all cells shift or load in parallel.
// Read, count and dump rotate the cell chain once around: DEPTH cycles, plus
// any cycles the output is stalled. Results leave through one output register.
// Synchronous reset clears every cell to zero and empties the output register.
// A stalled output holds the rotation; a new command waits until the chain is idle.
`default_nettype none

`include "shifting_array_store_defines.svh"

module shifting_array_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sas_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sas_pkg::out_item_t   out_item
);
  import sas_pkg::*;

  logic [WORD_W-1:0] word_w [DEPTH];
  cell_cmd_t         cell_cmd;

  state_e            state_r, state_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  acc_r, acc_nxt;
  logic [WORD_W-1:0] rd_r, rd_nxt;
  in_item_t          cmd_r, cmd_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              adv;
  logic              accept;
  logic              idx_ok;
  logic              uses_idx;
  logic              is_last;
  logic              match;
  logic              hit;
  logic              emit;
  out_item_t         res;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_W-1:0] low_w;
    logic [WORD_W-1:0] high_w;
    if (g == 0) begin : g_first
      assign low_w = '0;
    end else begin : g_mid_lo
      assign low_w = word_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_final
      assign high_w = cell_cmd.rot ? word_w[0] : '0;
    end else begin : g_mid_hi
      assign high_w = word_w[g+1];
    end
    sas_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cell_cmd),
      .pos       (POS_W'(g)),
      .low_word  (low_w),
      .high_word (high_w),
      .word      (word_w[g])
    );
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
    adv      = !out_valid_r || !out_stall;
    accept   = in_valid && !in_stall;
    idx_ok   = ({1'b0, in_item.index} < (IDX_W + 1)'(DEPTH));
    uses_idx = (in_item.kind == KIND_READ) || (in_item.kind == KIND_INSERT) ||
               (in_item.kind == KIND_REMOVE) || (in_item.kind == KIND_SET);
    is_last  = (cnt_r == POS_W'(DEPTH - 1));
    match    = (word_w[0] == cmd_r.value);
    hit      = (cnt_r == cmd_r.index[POS_W-1:0]);

    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    acc_nxt        = acc_r;
    rd_nxt         = rd_r;
    cmd_nxt        = cmd_r;
    cell_cmd.upd   = 1'b0;
    cell_cmd.rot   = 1'b0;
    cell_cmd.kind  = in_item.kind;
    cell_cmd.index = in_item.index;
    cell_cmd.value = in_item.value;
    emit           = 1'b0;
    res            = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (uses_idx && !idx_ok) begin
            emit         = 1'b1;
            res.op_error = 1'b1;
            res.last     = 1'b1;
          end else begin
            case (kind_e'(in_item.kind))
              KIND_READ, KIND_COUNT, KIND_DUMP: begin
                state_nxt = ST_SCAN;
                cmd_nxt   = in_item;
                cnt_nxt   = '0;
                acc_nxt   = '0;
              end
              KIND_INSERT, KIND_REMOVE, KIND_SET: begin
                cell_cmd.upd = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (adv) begin
          cell_cmd.rot = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
          acc_nxt      = acc_r + CNT_W'(match);
          if (hit) begin
            rd_nxt = word_w[0];
          end
          case (kind_e'(cmd_r.kind))
            KIND_DUMP: begin
              emit     = 1'b1;
              res.data = word_w[0];
              res.last = is_last;
            end
            KIND_READ: begin
              emit     = is_last;
              res.data = hit ? word_w[0] : rd_r;
              res.last = 1'b1;
            end
            KIND_COUNT: begin
              emit     = is_last;
              res.data = WORD_W'(acc_nxt);
              res.last = 1'b1;
            end
            default: begin
            end
          endcase
          if (is_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
    out_item_nxt  = emit ? res : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    rd_r       <= rd_nxt;
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SAS_ASSERT_NEXT(a_scan_holds, clk, rst_n, state_r == ST_SCAN && !adv, $stable(cnt_r))
  `SAS_ASSERT_NEXT(a_scan_ends, clk, rst_n, state_r == ST_SCAN && adv && is_last, state_r == ST_IDLE)
  `SAS_ASSERT_SAME(a_err_form, clk, rst_n, out_valid_r && out_item_r.op_error, out_item_r.last && out_item_r.data == 0)

endmodule

`default_nettype wire
